[src/cleb_pkg.sv]
// shared types and constants of the cursor line edit buffer
// no dependencies, compile first
`default_nettype none

package cleb_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int CHAR_W           = 8;
    localparam int ACTION_W         = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TYPE  = 3'd0,
        ACT_LEFT  = 3'd1,
        ACT_RIGHT = 3'd2,
        ACT_BACK  = 3'd3,
        ACT_CLEAR = 3'd4,
        ACT_READ  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_L,
        ST_MOVE_R,
        ST_READ_ADDR,
        ST_READ_LOAD
    } state_t;

    typedef enum logic [1:0] {
        RD_LEFT_PREV,
        RD_RIGHT_TOP,
        RD_LINE
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_TYPE,
        WR_GAP_TOP,
        WR_GAP_BOTTOM
    } wr_sel_t;

    typedef enum logic [2:0] {
        LEN_HOLD,
        LEN_TYPE,
        LEN_MOVE_L,
        LEN_MOVE_R,
        LEN_BACK,
        LEN_CLEAR
    } len_op_t;

    typedef struct packed {
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        len_op_t len_op;
        logic    ovf_set;
        logic    cnt_clear;
        logic    cnt_inc;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic left_zero;
        logic right_zero;
        logic full;
        logic read_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[src/cleb_if.sv]
// valid/ready channel interfaces for edit actions and read out beats
// depends on cleb_pkg
`default_nettype none

interface cleb_in_if;
    logic                        valid;
    logic                        ready;
    logic [cleb_pkg::ACTION_W-1:0] action;
    logic [cleb_pkg::CHAR_W-1:0]   char_in;

    modport source (output valid, output action, output char_in, input ready);
    modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface cleb_out_if;
    logic                        valid;
    logic                        ready;
    logic [cleb_pkg::CHAR_W-1:0] char_out;
    logic                        last;
    logic                        empty_res;
    logic                        overflow;

    modport source (output valid, output char_out, output last, output empty_res,
                    output overflow, input ready);
    modport sink   (input valid, input char_out, input last, input empty_res,
                    input overflow, output ready);
endinterface

`default_nettype wire

[src/cleb_ctrl.sv]
// control state machine of the line buffer
// depends on cleb_pkg
`default_nettype none

module cleb_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire logic [cleb_pkg::ACTION_W-1:0] cmd_action,
    output logic                               cmd_ready,
    input  wire cleb_pkg::status_t             status,
    output cleb_pkg::cmd_t                     ctl
);

    cleb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cleb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cleb_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_action)
                        cleb_pkg::ACT_LEFT:
                        begin
                            if (!status.left_zero)
                            begin
                                state_next = cleb_pkg::ST_MOVE_L;
                            end
                        end
                        cleb_pkg::ACT_RIGHT:
                        begin
                            if (!status.right_zero)
                            begin
                                state_next = cleb_pkg::ST_MOVE_R;
                            end
                        end
                        cleb_pkg::ACT_READ:
                        begin
                            state_next = cleb_pkg::ST_READ_ADDR;
                        end
                        default:
                        begin
                            state_next = cleb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            cleb_pkg::ST_MOVE_L, cleb_pkg::ST_MOVE_R:
            begin
                state_next = cleb_pkg::ST_IDLE;
            end
            cleb_pkg::ST_READ_ADDR:
            begin
                state_next = cleb_pkg::ST_READ_LOAD;
            end
            cleb_pkg::ST_READ_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = status.read_last ? cleb_pkg::ST_IDLE
                                                  : cleb_pkg::ST_READ_ADDR;
                end
            end
            default:
            begin
                state_next = cleb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_ready     = 1'b0;
        ctl           = '0;
        ctl.rd_sel    = cleb_pkg::RD_LINE;
        ctl.wr_sel    = cleb_pkg::WR_TYPE;
        ctl.len_op    = cleb_pkg::LEN_HOLD;
        case (state_reg)
            cleb_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (cmd_action)
                        cleb_pkg::ACT_TYPE:
                        begin
                            if (status.full)
                            begin
                                ctl.ovf_set = 1'b1;
                            end
                            else
                            begin
                                ctl.wr_en  = 1'b1;
                                ctl.wr_sel = cleb_pkg::WR_TYPE;
                                ctl.len_op = cleb_pkg::LEN_TYPE;
                            end
                        end
                        cleb_pkg::ACT_LEFT:
                        begin
                            ctl.rd_en  = !status.left_zero;
                            ctl.rd_sel = cleb_pkg::RD_LEFT_PREV;
                        end
                        cleb_pkg::ACT_RIGHT:
                        begin
                            ctl.rd_en  = !status.right_zero;
                            ctl.rd_sel = cleb_pkg::RD_RIGHT_TOP;
                        end
                        cleb_pkg::ACT_BACK:
                        begin
                            if (!status.left_zero)
                            begin
                                ctl.len_op = cleb_pkg::LEN_BACK;
                            end
                        end
                        cleb_pkg::ACT_CLEAR:
                        begin
                            ctl.len_op = cleb_pkg::LEN_CLEAR;
                        end
                        cleb_pkg::ACT_READ:
                        begin
                            ctl.cnt_clear = 1'b1;
                        end
                        default:
                        begin
                            ctl.len_op = cleb_pkg::LEN_HOLD;
                        end
                    endcase
                end
            end
            cleb_pkg::ST_MOVE_L:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = cleb_pkg::WR_GAP_TOP;
                ctl.len_op = cleb_pkg::LEN_MOVE_L;
            end
            cleb_pkg::ST_MOVE_R:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = cleb_pkg::WR_GAP_BOTTOM;
                ctl.len_op = cleb_pkg::LEN_MOVE_R;
            end
            cleb_pkg::ST_READ_ADDR:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = cleb_pkg::RD_LINE;
            end
            cleb_pkg::ST_READ_LOAD:
            begin
                if (status.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.cnt_inc  = !status.read_last;
                end
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/cleb_datapath.sv]
// gap buffer store, length counters, read index and output register
// depends on cleb_pkg
`default_nettype none

module cleb_datapath #(
    parameter int CAPACITY = cleb_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cleb_pkg::cmd_t              ctl,
    output cleb_pkg::status_t                status,
    input  wire logic [cleb_pkg::CHAR_W-1:0] char_in,
    input  wire logic                        res_ready,
    output logic                             res_valid,
    output logic [cleb_pkg::CHAR_W-1:0]      char_out,
    output logic                             last,
    output logic                             empty_res,
    output logic                             overflow
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
    localparam logic [LW-1:0] ONE_L = LW'(1);

    logic [cleb_pkg::CHAR_W-1:0] store_mem [CAPACITY];
    logic [cleb_pkg::CHAR_W-1:0] rd_data_reg;

    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] right_reg, right_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] idx_reg, idx_next;

    logic                        out_valid_reg, out_valid_next;
    logic [cleb_pkg::CHAR_W-1:0] out_char_reg;
    logic                        out_last_reg;
    logic                        out_empty_reg;
    logic                        out_ovf_reg;

    logic [LW-1:0]               total;
    logic [LW-1:0]               rd_addr_w;
    logic [LW-1:0]               wr_addr_w;
    logic [cleb_pkg::CHAR_W-1:0] wr_data;

    assign total = left_reg + right_reg;

    always_comb
    begin
        case (ctl.rd_sel)
            cleb_pkg::RD_LEFT_PREV: rd_addr_w = left_reg - ONE_L;
            cleb_pkg::RD_RIGHT_TOP: rd_addr_w = CAP_L - right_reg;
            // left part in place, right part shifted up past the gap
            cleb_pkg::RD_LINE:
                rd_addr_w = (idx_reg < left_reg) ? idx_reg : idx_reg + (CAP_L - total);
            default:                rd_addr_w = idx_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.wr_sel)
            cleb_pkg::WR_TYPE:
            begin
                wr_addr_w = left_reg;
                wr_data   = char_in;
            end
            cleb_pkg::WR_GAP_TOP:
            begin
                wr_addr_w = CAP_L - right_reg - ONE_L;
                wr_data   = rd_data_reg;
            end
            cleb_pkg::WR_GAP_BOTTOM:
            begin
                wr_addr_w = left_reg;
                wr_data   = rd_data_reg;
            end
            default:
            begin
                wr_addr_w = left_reg;
                wr_data   = char_in;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store_mem[wr_addr_w[IW-1:0]] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr_w[IW-1:0]];
        end
    end

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        ovf_next   = ovf_reg | ctl.ovf_set;
        case (ctl.len_op)
            cleb_pkg::LEN_HOLD:   left_next = left_reg;
            cleb_pkg::LEN_TYPE:   left_next = left_reg + ONE_L;
            cleb_pkg::LEN_MOVE_L:
            begin
                left_next  = left_reg - ONE_L;
                right_next = right_reg + ONE_L;
            end
            cleb_pkg::LEN_MOVE_R:
            begin
                left_next  = left_reg + ONE_L;
                right_next = right_reg - ONE_L;
            end
            cleb_pkg::LEN_BACK:   left_next = left_reg - ONE_L;
            cleb_pkg::LEN_CLEAR:
            begin
                left_next  = '0;
                right_next = '0;
                ovf_next   = 1'b0;
            end
            default:              left_next = left_reg;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.cnt_clear)
        begin
            idx_next = '0;
        end
        else if (ctl.cnt_inc)
        begin
            idx_next = idx_reg + ONE_L;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid_next = ctl.out_load ? 1'b1 : (out_valid_reg & ~res_ready);

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_char_reg  <= (total == '0) ? '0 : rd_data_reg;
            out_last_reg  <= status.read_last;
            out_empty_reg <= (total == '0);
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign status.left_zero  = (left_reg == '0);
    assign status.right_zero = (right_reg == '0);
    assign status.full       = (total >= CAP_L);
    assign status.read_last  = (total == '0) || (idx_reg + ONE_L == total);
    assign status.out_free   = !out_valid_reg || res_ready;

    assign res_valid = out_valid_reg;
    assign char_out  = out_char_reg;
    assign last      = out_last_reg;
    assign empty_res = out_empty_reg;
    assign overflow  = out_ovf_reg;

endmodule

`default_nettype wire

[src/cursor_line_edit_buffer.sv]
// top level of the cursor line edit buffer: controller plus datapath
// depends on cleb_pkg, cleb_if, cleb_ctrl, cleb_datapath
`default_nettype none

// one line of up to CAPACITY bytes with a cursor, held as a gap buffer in a
// single-port-write, single-port-read memory: text left of the cursor grows
// up from entry 0, text right of the cursor sits at the top of the memory.
// each cmd beat is one edit action. type, backspace, clear and the unused
// codes are done in the idle state; left and right pass through a move
// state when the cursor moves, since the byte crossing the gap is read from
// the memory in idle and written back in the move state, and stay idle
// when the cursor already sits at that end. read out takes the action beat
// in idle and then, for each res beat, a memory read state and an output
// register load state, the load waiting while res is stalled; an empty
// line gives one beat with empty_res and last set. the last res beat may
// still wait in the output register while the next cmd beat is taken.
// overflow on every res beat shows the sticky flag, which a type into a
// full line sets and clear resets. no clearing pass is needed after reset:
// unwritten memory is read only for an empty line, whose byte is zeroed.

module cursor_line_edit_buffer #(
    parameter int CAPACITY = cleb_pkg::DEFAULT_CAPACITY
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cleb_in_if.sink     cmd,
    cleb_out_if.source  res
);

    // command and status bundles between controller and datapath
    cleb_pkg::cmd_t    ctl;
    cleb_pkg::status_t status;

    cleb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_action (cmd.action),
        .cmd_ready  (cmd.ready),
        .status     (status),
        .ctl        (ctl)
    );

    // store, lengths, read index and the output register
    cleb_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .char_in   (cmd.char_in),
        .res_ready (res.ready),
        .res_valid (res.valid),
        .char_out  (res.char_out),
        .last      (res.last),
        .empty_res (res.empty_res),
        .overflow  (res.overflow)
    );

endmodule

`default_nettype wire

[src/cleb_checker.sv]
// port level checks of the cursor line edit buffer and their bind
// depends on cleb_pkg and cursor_line_edit_buffer
`default_nettype none

module cleb_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_ready,
    input wire logic [cleb_pkg::ACTION_W-1:0] cmd_action,
    input wire logic                          res_valid,
    input wire logic                          res_ready,
    input wire logic [cleb_pkg::CHAR_W-1:0]   char_out,
    input wire logic                          last,
    input wire logic                          empty_res,
    input wire logic                          overflow
);

    // a stalled beat keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(char_out) && $stable(last)
            && $stable(empty_res) && $stable(overflow))
        else $error("res beat changed while stalled");

    // the empty beat stands alone and carries a zero byte
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && empty_res |-> last && (char_out == '0))
        else $error("empty beat without last or with nonzero byte");

    // a read out keeps the block busy in the following cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_action == cleb_pkg::ACT_READ) |=> !cmd_ready)
        else $error("cmd taken right after read out");

    // overflow is the same on consecutive beats of one read out
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last ##1 res_valid |-> overflow == $past(overflow))
        else $error("overflow changed within a read out");

endmodule

bind cursor_line_edit_buffer cleb_checker u_cleb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_action (cmd.action),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .char_out   (res.char_out),
    .last       (res.last),
    .empty_res  (res.empty_res),
    .overflow   (res.overflow)
);

`default_nettype wire
